>>> src/qph_pkg.sv
// Shared constants for the quadratic probe hash table: field widths, opcodes, status codes.
package qph_pkg;

   localparam int KEY_W     = 31;
   localparam int STATUS_W  = 2;
   localparam int SLOT_W    = 4;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 8;

   typedef logic [KEY_W-1:0]    key_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [SLOT_W-1:0]   slot_type;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   localparam status_type STAT_INSERTED = 2'd0;
   localparam status_type STAT_FULL     = 2'd1;
   localparam status_type STAT_FOUND    = 2'd2;
   localparam status_type STAT_MISSING  = 2'd3;

endpackage

>>> src/quadratic_probe_hash_table_core.sv
// Open-addressing hash table with quadratic probing, insert and search, one slot probe a cycle.
// Flow: a power-of-two size goes from IDLE straight to PROBE, then FIN; any other size first
//   passes HASH and REDUCE for the reciprocal-multiply key mod TABLE_SIZE reduction. A request
//   with no hit in TABLE_SIZE probes ends as full (insert) or missing (search).
// Throughput: one request at a time; the next is taken the cycle after the result is latched.
// Reset: synchronous; the block then sweeps every slot of the RAM to empty, req_tready low.
module quadratic_probe_hash_table_core
   import qph_pkg::*;
#(
   parameter int TABLE_SIZE = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [30:0] key, [31] zero pad
   input  logic                  req_tuser,   // [0] opcode
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [3:0] slot, [7:4] zero pad
   output logic [STATUS_W-1:0]   rsp_tuser    // [1:0] status
);

   localparam int IDX_W    = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
   localparam int CNT_W    = $clog2(TABLE_SIZE + 1);
   localparam bit POW2     = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;
   localparam int PROD_W   = KEY_W + 32;
   localparam int RECIP_SH = KEY_W + IDX_W;

   localparam logic [IDX_W:0]    NUM_EXT  = (IDX_W+1)'(TABLE_SIZE);
   localparam logic [CNT_W-1:0]  NUM_CNT  = CNT_W'(TABLE_SIZE);
   localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(TABLE_SIZE - 1);
   localparam key_type           NUM_KEY  = KEY_W'(TABLE_SIZE);

   // Rounded-up reciprocal: exact quotient for every 31-bit key
   localparam logic [63:0] RECIP_WIDE =
      ((64'd1 << RECIP_SH) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
   localparam logic [31:0] RECIP = RECIP_WIDE[31:0];

   // Sequencer codes
   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_HASH   = 3'd2;
   localparam logic [2:0] ST_PROBE  = 3'd3;
   localparam logic [2:0] ST_FIN    = 3'd4;
   localparam logic [2:0] ST_REDUCE = 3'd5;

   // Slot RAM: used flag on top of the stored key
   logic [KEY_W:0] slot_mem [TABLE_SIZE];

   logic [2:0]        state_ff,   state_in;
   logic [IDX_W-1:0]  clr_ff,     clr_in;
   logic              op_ff,      op_in;
   key_type           key_ff,     key_in;
   key_type           quot_ff,    quot_in;
   logic [IDX_W-1:0]  pos_ff,     pos_in;
   logic [IDX_W-1:0]  d_ff,       d_in;
   logic [CNT_W-1:0]  cnt_ff,     cnt_in;
   logic              rd_vld_ff,  rd_vld_in;
   logic [IDX_W-1:0]  rd_pos_ff,  rd_pos_in;
   logic [KEY_W:0]    rd_data_ff;
   status_type        res_status_ff, res_status_in;
   logic [IDX_W-1:0]  res_slot_ff,   res_slot_in;
   logic              rsp_valid_ff,  rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   slot_type          rsp_slot_ff,   rsp_slot_in;

   logic              mem_we;
   logic [IDX_W-1:0]  mem_wa;
   logic [KEY_W:0]    mem_wd;
   logic              rd_en;

   logic [PROD_W-1:0] recip_prod;
   key_type           key_rem;
   logic [IDX_W:0]    pos_sum;
   logic [IDX_W:0]    pos_adv;
   logic [IDX_W:0]    d_sum;
   logic [IDX_W:0]    d_adv;
   logic              slot_used;
   logic              key_match;

   // Home slot for a size that is not a power of two: quotient by reciprocal multiply in HASH,
   // remainder by multiply-back and subtract in REDUCE after it. The probe step
   // (home + i*i) mod N is kept as running sums with one compare-subtract per sum.
   assign recip_prod = PROD_W'(key_ff) * PROD_W'(RECIP);
   assign key_rem    = key_ff - quot_ff * NUM_KEY;
   assign pos_sum    = {1'b0, pos_ff} + {1'b0, d_ff};
   assign pos_adv    = (pos_sum >= NUM_EXT) ? pos_sum - NUM_EXT : pos_sum;
   assign d_sum      = {1'b0, d_ff} + (IDX_W+1)'(2);
   assign d_adv      = (d_sum >= NUM_EXT) ? d_sum - NUM_EXT : d_sum;

   assign slot_used = rd_data_ff[KEY_W];
   assign key_match = rd_data_ff[KEY_W-1:0] == key_ff;

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      quot_in       = quot_ff;
      pos_in        = pos_ff;
      d_in          = d_ff;
      cnt_in        = cnt_ff;
      rd_vld_in     = 1'b0;
      rd_pos_in     = rd_pos_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      mem_we        = 1'b0;
      mem_wa        = rd_pos_ff;
      mem_wd        = {1'b1, key_ff};
      rd_en         = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            // Sweep every slot to empty
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tuser;
               key_in   = req_tdata[KEY_W-1:0];
               pos_in   = req_tdata[IDX_W-1:0];
               d_in     = IDX_W'(1);
               cnt_in   = '0;
               state_in = POW2 ? ST_PROBE : ST_HASH;
            end
         end
         ST_HASH: begin
            // Quotient of the key by the table size
            quot_in  = KEY_W'(recip_prod >> RECIP_SH);
            state_in = ST_REDUCE;
         end
         ST_REDUCE: begin
            // Remainder is the home slot
            pos_in   = key_rem[IDX_W-1:0];
            state_in = ST_PROBE;
         end
         ST_PROBE: begin
            // Check the slot read last cycle while the next read goes out
            if (rd_vld_ff && !slot_used) begin
               if (op_ff == OP_INSERT) begin
                  mem_we        = 1'b1;
                  res_status_in = STAT_INSERTED;
                  res_slot_in   = rd_pos_ff;
               end else begin
                  res_status_in = STAT_MISSING;
                  res_slot_in   = '0;
               end
               state_in = ST_FIN;
            end else if (rd_vld_ff && op_ff == OP_SEARCH && key_match) begin
               res_status_in = STAT_FOUND;
               res_slot_in   = rd_pos_ff;
               state_in      = ST_FIN;
            end else if (cnt_ff != NUM_CNT) begin
               rd_en     = 1'b1;
               rd_vld_in = 1'b1;
               rd_pos_in = pos_ff;
               pos_in    = pos_adv[IDX_W-1:0];
               d_in      = d_adv[IDX_W-1:0];
               cnt_in    = cnt_ff + 1'b1;
            end else if (!rd_vld_ff) begin
               // All probes used without a hit
               res_status_in = (op_ff == OP_INSERT) ? STAT_FULL : STAT_MISSING;
               res_slot_in   = '0;
               state_in      = ST_FIN;
            end
         end
         ST_FIN: begin
            // Hand the result to the output register once it is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = SLOT_W'(res_slot_ff);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         cnt_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      quot_ff       <= quot_in;
      pos_ff        <= pos_in;
      d_ff          <= d_in;
      rd_pos_ff     <= rd_pos_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   // Slot RAM: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_wa] <= mem_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= slot_mem[pos_ff];
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W-SLOT_W)'(0), rsp_slot_ff};
   assign rsp_tuser  = rsp_status_ff;

   // A taken request always starts work
   a_req_starts: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff != ST_IDLE)
      else $error("accepted request did not leave idle");

   // A slot read in flight means at least one probe was issued
   a_rd_has_probe: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> cnt_ff != '0)
      else $error("read valid without an issued probe");

   // Probe position and step stay reduced below the table size
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PROBE |-> {1'b0, pos_ff} < NUM_EXT && {1'b0, d_ff} < NUM_EXT)
      else $error("probe position or step out of range");

   // Full and missing results carry slot zero
   a_miss_slot_zero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FIN && (res_status_ff == STAT_FULL || res_status_ff == STAT_MISSING)
      |-> res_slot_ff == '0)
      else $error("miss result with nonzero slot");

endmodule

>>> tb/qph_outcome_checker.sv
// Scoreboard for the quadratic probe hash table: tracks the slot table and checks each result beat.
`timescale 1ns / 1ps

module qph_outcome_checker
   import qph_pkg::*;
#(
   parameter int TABLE_SIZE = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [30:0] key, [31] zero pad
   input  logic                  req_tuser,   // [0] opcode
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // [3:0] slot, [7:4] zero pad
   input  logic [STATUS_W-1:0]   rsp_tuser,   // [1:0] status
   output int                    fail_count,
   output int                    outstanding,
   output int                    inserted_count,
   output int                    full_count,
   output int                    found_count,
   output int                    missing_count
);

   typedef struct packed {
      status_type status;
      slot_type   slot;
   } outcome_type;

   outcome_type expected_outcomes[$];
   key_type     table_key [TABLE_SIZE];
   bit          table_used [TABLE_SIZE];
   int          errors = 0;
   int          tally [4] = '{0, 0, 0, 0};

   // Walk the probe sequence home + n*n and update the table on an insert.
   function automatic outcome_type probe_table(logic op, key_type key);
      int          home;
      int          pos;
      int          n;
      outcome_type res;
      home       = int'(key % TABLE_SIZE);
      res.status = (op == OP_INSERT) ? STAT_FULL : STAT_MISSING;
      res.slot   = '0;
      for (n = 0; n < TABLE_SIZE; n++) begin
         pos = (home + n * n) % TABLE_SIZE;
         if (!table_used[pos]) begin
            if (op == OP_INSERT) begin
               table_used[pos] = 1'b1;
               table_key[pos]  = key;
               res.status      = STAT_INSERTED;
               res.slot        = slot_type'(pos);
            end
            break;
         end
         if (op == OP_SEARCH && table_key[pos] == key) begin
            res.status = STAT_FOUND;
            res.slot   = slot_type'(pos);
            break;
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         foreach (table_used[i]) table_used[i] = 1'b0;
         expected_outcomes.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_outcomes.size() == 0) begin
               $error("unexpected result beat: status %0d slot %0d", rsp_tuser,
                      rsp_tdata[SLOT_W-1:0]);
               errors++;
            end else begin
               want = expected_outcomes.pop_front();
               if (rsp_tuser !== want.status) begin
                  $error("status mismatch: expected %0d, got %0d", want.status, rsp_tuser);
                  errors++;
               end
               if (rsp_tdata[SLOT_W-1:0] !== want.slot) begin
                  $error("slot mismatch: expected %0d, got %0d", want.slot,
                         rsp_tdata[SLOT_W-1:0]);
                  errors++;
               end
               tally[want.status]++;
            end
         end
         if (req_tvalid && req_tready)
            expected_outcomes.push_back(probe_table(req_tuser, req_tdata[KEY_W-1:0]));
      end
      fail_count     <= errors;
      outstanding    <= expected_outcomes.size();
      inserted_count <= tally[STAT_INSERTED];
      full_count     <= tally[STAT_FULL];
      found_count    <= tally[STAT_FOUND];
      missing_count  <= tally[STAT_MISSING];
   end

endmodule

>>> tb/testbench.sv
// Top of the hash table bench: clock, reset, request stimulus, result back-pressure and verdict.
`timescale 1ns / 1ps

module testbench;
   import qph_pkg::*;

   localparam int TABLE_SIZE   = 16;
   localparam int RANDOM_ITEMS = 1850;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // [30:0] key, [31] zero pad
   logic                  req_tuser = 1'b0; // [0] opcode
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // [3:0] slot, [7:4] zero pad
   logic [STATUS_W-1:0]   rsp_tuser;        // [1:0] status

   int fail_count;
   int outstanding;
   int inserted_count;
   int full_count;
   int found_count;
   int missing_count;

   // Idle percentages for each side; the stimulus process moves them between phases.
   int send_idle_pct = 23;
   int recv_idle_pct = 63;

   int      insert_reqs = 0;
   int      search_reqs = 0;
   key_type known_keys[$];

   quadratic_probe_hash_table_core #(
      .TABLE_SIZE (TABLE_SIZE)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   qph_outcome_checker #(
      .TABLE_SIZE (TABLE_SIZE)
   ) outcome_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .fail_count     (fail_count),
      .outstanding    (outstanding),
      .inserted_count (inserted_count),
      .full_count     (full_count),
      .found_count    (found_count),
      .missing_count  (missing_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Back-pressure on the result channel: drop tready at the current idle rate.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Present one request beat and hold it until the block takes it. Idle cycles in front
   // of the beat lower tvalid; with no idle cycle tvalid stays high from the previous beat.
   task automatic issue_request(input logic op, input key_type key);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, key};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      if (op == OP_INSERT) begin
         insert_reqs++;
         known_keys.push_back(key);
      end else begin
         search_reqs++;
      end
   endtask

   // Mix small keys, full-width keys, keys crowded onto four home slots, and keys that
   // share a home with one already seen so that probe chains get long.
   function automatic key_type random_key();
      case ($urandom_range(3))
         0: return key_type'($urandom_range(63));
         1: return key_type'($urandom);
         2: return key_type'($urandom_range(4095) * TABLE_SIZE + $urandom_range(3));
         default: begin
            if (known_keys.size() == 0) return key_type'($urandom_range(63));
            return known_keys[$urandom_range(known_keys.size() - 1)]
                   + key_type'(TABLE_SIZE * $urandom_range(1, 7));
         end
      endcase
   endfunction

   initial begin
      logic    op;
      key_type key;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty-slot miss, field extremes, collisions on home slot zero until the
      // reachable probe set is exhausted, then searches that hit, miss at an empty slot,
      // and miss after running out of probes.
      issue_request(OP_SEARCH, key_type'(0));
      issue_request(OP_INSERT, key_type'(0));
      issue_request(OP_INSERT, key_type'(31'h7FFF_FFFF));
      issue_request(OP_SEARCH, key_type'(31'h7FFF_FFFF));
      issue_request(OP_INSERT, key_type'(16));
      issue_request(OP_INSERT, key_type'(32));
      issue_request(OP_INSERT, key_type'(0));
      issue_request(OP_INSERT, key_type'(48));
      issue_request(OP_SEARCH, key_type'(48));
      issue_request(OP_SEARCH, key_type'(0));
      issue_request(OP_SEARCH, key_type'(32));
      issue_request(OP_SEARCH, key_type'(31'h4000_0000));
      issue_request(OP_INSERT, key_type'(31'h5555_5555));
      issue_request(OP_INSERT, key_type'(31'h2AAA_AAAA));
      issue_request(OP_SEARCH, key_type'(31'h5555_5555));
      issue_request(OP_SEARCH, key_type'(31'h2AAA_AAAA));
      issue_request(OP_SEARCH, key_type'(21));
      issue_request(OP_SEARCH, key_type'(31'h7FFF_FFEF));

      // Random part in three idle phases: sender light and receiver heavy, then swapped,
      // then both sides at full rate.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 3) begin
            send_idle_pct = 63;
            recv_idle_pct = 23;
         end else if (i == 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         op = ($urandom_range(99) < 40) ? OP_INSERT : OP_SEARCH;
         if (op == OP_SEARCH && known_keys.size() != 0 && $urandom_range(99) < 60)
            key = known_keys[$urandom_range(known_keys.size() - 1)];
         else
            key = random_key();
         issue_request(op, key);
      end
      req_tvalid <= 1'b0;

      // Drain: let the checker count the last beat, wait for every outstanding result,
      // then give the block time to misbehave.
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (TABLE_SIZE + 40) @(posedge clock);

      $display("covered %0d inserts and %0d searches over three idle phases",
               insert_reqs, search_reqs);
      $display("results: %0d inserted, %0d full, %0d found, %0d missing",
               inserted_count, full_count, found_count, missing_count);
      if (fail_count == 0 && outstanding == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Watchdog: a hung handshake ends the run here.
   initial begin
      #10_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
